// ----- hdl/ebs_pkg.sv -----
// ----------------------------------------------------------------------------
// ebs_pkg
// Shared types and constants of the eikonal block sweep.
// ----------------------------------------------------------------------------
package ebs_pkg;

	// Default interior edge of a tile.
	localparam int EBS_TILE_EDGE = 4;
	// Width of the step register.
	localparam int STEP_W = 25;
	// Reset value of the step register, 1.0 in unsigned Q9.16.
	localparam logic [STEP_W-1:0] STEP_RESET = 25'd65536;
	// Width of the discriminant, padded to an even number of bits.
	localparam int DISC_W = 52;
	// Width of the root.
	localparam int ROOT_W = DISC_W / 2;
	// Queue depths.
	localparam int CELL_Q_DEPTH = 4;
	localparam int OUT_Q_DEPTH = 2;

	typedef struct packed {
		logic [31:0] cell_value;
		logic        first_cell;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        is_mean;
		logic        last_result;
	} out_item_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_RD,
		BK_MIN,
		BK_MUL,
		BK_SUB,
		BK_ROOT,
		BK_CAND,
		BK_WB,
		BK_ORD,
		BK_OPUSH,
		BK_DIV,
		BK_MEAN
	} back_state_t;

endpackage

// ----- hdl/ebs_ram.sv -----
// ----------------------------------------------------------------------------
// ebs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ebs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/ebs_fifo.sv -----
// ----------------------------------------------------------------------------
// ebs_fifo
// Small synchronous queue built from flip-flops.
// ----------------------------------------------------------------------------
module ebs_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

endmodule

// ----- hdl/ebs_front.sv -----
// ----------------------------------------------------------------------------
// ebs_front
// Input side: numbers each incoming cell and marks the one closing a tile.
// ----------------------------------------------------------------------------
module ebs_front
	import ebs_pkg::*;
#(
	parameter int CELLS = 36
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  in_item_t                 item,
	output logic                     cq_wr,
	output logic [31:0]              cq_value,
	output logic [$clog2(CELLS)-1:0] cq_addr,
	output logic                     cq_last,
	input  logic                     cq_full
);

	localparam int AW = $clog2(CELLS);

	logic [AW-1:0] load_count_q;
	logic          take;

	assign full     = cq_full;
	assign take     = push && !cq_full;
	assign cq_wr    = take;
	assign cq_value = item.cell_value;
	assign cq_addr  = item.first_cell ? '0 : load_count_q;
	assign cq_last  = (cq_addr == AW'(CELLS - 1));

	// Load counter; a first cell restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (take) begin
			load_count_q <= cq_last ? '0 : cq_addr + 1'b1;
		end
	end

endmodule

// ----- hdl/ebs_sqrt.sv -----
// ----------------------------------------------------------------------------
// ebs_sqrt
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ebs_sqrt
	import ebs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DISC_W-1:0] operand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 4;
	localparam int IW = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [IW-1:0]     iter_q;
	logic [DISC_W-1:0] rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[DISC_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);
	assign done   = done_q;
	assign root   = root_q;

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == IW'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One digit pair of the radicand per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[DISC_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

endmodule

// ----- hdl/ebs_back.sv -----
// ----------------------------------------------------------------------------
// ebs_back
// Execution side: stores cells, runs the sweep, emits cells and the mean.
// ----------------------------------------------------------------------------
module ebs_back
	import ebs_pkg::*;
#(
	parameter int TILE_EDGE = 4
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [STEP_W-1:0]                            unit_step,
	input  logic                                         cq_empty,
	input  logic [31:0]                                  cq_value,
	input  logic [$clog2((TILE_EDGE+2)*(TILE_EDGE+2))-1:0] cq_addr,
	input  logic                                         cq_last,
	output logic                                         cq_rd,
	output logic                                         oq_wr,
	output out_item_t                                    oq_data,
	input  logic                                         oq_full
);

	localparam int SIDE  = TILE_EDGE + 2;
	localparam int CELLS = SIDE * SIDE;
	localparam int NINT  = TILE_EDGE * TILE_EDGE;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(TILE_EDGE + 1);
	localparam int SUM_W = 32 + $clog2(NINT);
	localparam int DCW   = 2;
	// Reciprocal of the interior cell count, scaled so that the estimate
	// is never more than one below the true quotient.
	localparam int HW    = (SUM_W + 1) / 2;
	localparam int RS    = SUM_W + 2;
	localparam int MW    = SUM_W + 1;
	localparam int PW    = 2 * SUM_W;
	localparam logic [MW-1:0] RECIP_M = MW'((64'd1 << RS) / 64'(NINT));

	back_state_t state_q, state_d;

	logic [AW-1:0]     k_q;
	logic [CW-1:0]     r_q, c_q;
	logic [2:0]        phase_q;
	logic [31:0]       nb_q [5];
	logic [31:0]       tmin_q;
	logic [32:0]       txy_q;
	logic [STEP_W-1:0] d_q;
	logic              ge_q;
	logic [49:0]       dsq_q, ssq_q;
	logic [DISC_W-1:0] disc;
	logic [31:0]       new_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  div_q;
	logic [DCW-1:0]    dcnt_q;
	logic [PW-1:0]     prod_q;
	logic [31:0]       qest_q;
	logic [31:0]       mean_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [31:0]       wdata, rdata;
	logic              sq_start, sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic              last_cell;

	logic [31:0]       tx, ty, dd;
	logic [32:0]       cand;
	logic [33:0]       wide;
	logic [31:0]       cand_sat;
	logic [PW-1:0]     pp_lo, pp_hi;
	logic [SUM_W-1:0]  qn, mrem;

	assign last_cell = (r_q == CW'(TILE_EDGE)) && (c_q == CW'(TILE_EDGE));

	ebs_ram #(.WIDTH(32), .DEPTH(CELLS)) u_tile (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ebs_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (disc),
		.done    (sq_done),
		.root    (sq_root)
	);

	// Neighbor minima and their distance.
	always_comb begin
		tx = (nb_q[0] < nb_q[1]) ? nb_q[0] : nb_q[1];
		ty = (nb_q[2] < nb_q[3]) ? nb_q[2] : nb_q[3];
		dd = (tx > ty) ? tx - ty : ty - tx;
	end

	// Discriminant: two steps squared less the distance squared.
	assign disc = {1'b0, ssq_q, 1'b0} - {2'b00, dsq_q};

	// Candidate value with saturation.
	always_comb begin
		wide = {1'b0, txy_q} + {8'd0, sq_root};
		if (ge_q) begin
			cand = {1'b0, tmin_q} + {8'd0, unit_step};
		end else begin
			cand = wide[33:1];
		end
		cand_sat = cand[32] ? 32'hFFFF_FFFF : cand[31:0];
	end

	// Partial products of the sum with the reciprocal, and the remainder check.
	assign pp_lo = PW'(div_q[HW-1:0]) * PW'(RECIP_M);
	assign pp_hi = PW'(div_q[SUM_W-1:HW]) * PW'(RECIP_M);
	assign qn    = SUM_W'(qest_q) * SUM_W'(NINT);
	assign mrem  = div_q - qn;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (!cq_empty && cq_last) state_d = BK_RD;
			BK_RD:    if (phase_q == 3'd5) state_d = BK_MIN;
			BK_MIN:   state_d = BK_MUL;
			BK_MUL:   state_d = (ge_q) ? BK_CAND : BK_SUB;
			BK_SUB:   state_d = BK_ROOT;
			BK_ROOT:  if (sq_done) state_d = BK_CAND;
			BK_CAND:  state_d = BK_WB;
			BK_WB:    state_d = last_cell ? BK_ORD : BK_RD;
			BK_ORD:   state_d = BK_OPUSH;
			BK_OPUSH: if (!oq_full) state_d = last_cell ? BK_DIV : BK_ORD;
			BK_DIV:   if (dcnt_q == DCW'(3)) state_d = BK_MEAN;
			BK_MEAN:  if (!oq_full) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cq_rd    = 1'b0;
		we       = 1'b0;
		waddr    = k_q;
		wdata    = new_q;
		raddr    = k_q;
		sq_start = 1'b0;
		oq_wr    = 1'b0;
		oq_data  = '{result_value: rdata, is_mean: 1'b0, last_result: 1'b0};
		unique case (state_q)
			BK_IDLE: begin
				cq_rd = !cq_empty;
				we    = !cq_empty;
				waddr = cq_addr;
				wdata = cq_value;
			end
			BK_RD: begin
				unique case (phase_q)
					3'd0:    raddr = k_q - AW'(SIDE);
					3'd1:    raddr = k_q + AW'(SIDE);
					3'd2:    raddr = k_q - 1'b1;
					3'd3:    raddr = k_q + 1'b1;
					default: raddr = k_q;
				endcase
			end
			BK_SUB:   sq_start = 1'b1;
			BK_WB:    we = 1'b1;
			BK_OPUSH: oq_wr = !oq_full;
			BK_MEAN: begin
				oq_wr   = !oq_full;
				oq_data = '{result_value: mean_q, is_mean: 1'b1, last_result: 1'b1};
			end
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				k_q     <= AW'(SIDE + 1);
				r_q     <= CW'(1);
				c_q     <= CW'(1);
				phase_q <= '0;
				sum_q   <= '0;
			end
			BK_RD: begin
				if (phase_q != 3'd0) begin
					nb_q[phase_q - 1'b1] <= rdata;
				end
				phase_q <= phase_q + 1'b1;
			end
			BK_MIN: begin
				tmin_q <= (tx < ty) ? tx : ty;
				txy_q  <= {1'b0, tx} + {1'b0, ty};
				ge_q   <= (dd >= {7'd0, unit_step});
				d_q    <= dd[STEP_W-1:0];
			end
			BK_MUL: begin
				dsq_q <= 50'(d_q) * 50'(d_q);
				ssq_q <= 50'(unit_step) * 50'(unit_step);
			end
			BK_CAND: new_q <= (cand_sat < nb_q[4]) ? cand_sat : nb_q[4];
			BK_WB: begin
				phase_q <= '0;
				if (last_cell) begin
					k_q <= AW'(SIDE + 1);
					r_q <= CW'(1);
					c_q <= CW'(1);
				end else if (c_q == CW'(TILE_EDGE)) begin
					k_q <= k_q + AW'(3);
					c_q <= CW'(1);
					r_q <= r_q + 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
					c_q <= c_q + 1'b1;
				end
			end
			BK_OPUSH: begin
				if (!oq_full) begin
					sum_q  <= sum_q + SUM_W'(rdata);
					div_q  <= sum_q + SUM_W'(rdata);
					dcnt_q <= '0;
					if (c_q == CW'(TILE_EDGE)) begin
						k_q <= k_q + AW'(3);
						c_q <= CW'(1);
						r_q <= r_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
						c_q <= c_q + 1'b1;
					end
				end
			end
			BK_DIV: begin
				// Mean by multiplication with the reciprocal of the cell count,
				// then one correction step on the remainder.
				dcnt_q <= dcnt_q + 1'b1;
				unique case (dcnt_q)
					2'd0:    prod_q <= pp_lo;
					2'd1:    prod_q <= prod_q + (pp_hi << HW);
					2'd2:    qest_q <= prod_q[RS +: 32];
					default: mean_q <= (mrem >= SUM_W'(NINT)) ? qest_q + 1'b1 : qest_q;
				endcase
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/eikonal_block_sweep.sv -----
// ----------------------------------------------------------------------------
// eikonal_block_sweep
// One Godunov upwind sweep of the 2-D eikonal equation over a tile.
// ----------------------------------------------------------------------------
// A tile of (TILE_EDGE+2)^2 unsigned Q16.16 travel times, ghost ring included,
// is pushed in row-major order, one cell per transfer; first_cell restarts the
// load. The cell that closes the tile starts an in-place sweep over the
// interior; each interior cell takes five reads of the single tile RAM port
// plus compare and write, and the square-root branch adds a wait on the root
// unit, which resolves one bit per cycle. The updated interior cells then
// leave in row-major order, each held while the output queue is full,
// followed by their mean from a reciprocal multiplication, flagged is_mean and
// last_result. The next tile's cells queue up during the sweep until the cell
// queue fills.
module eikonal_block_sweep
	import ebs_pkg::*;
#(
	parameter int TILE_EDGE = EBS_TILE_EDGE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_item_t          item,
	output logic              empty,
	input  logic              pop,
	output out_item_t         result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [STEP_W-1:0] cfg_data
);

	localparam int CELLS = (TILE_EDGE + 2) * (TILE_EDGE + 2);
	localparam int AW    = $clog2(CELLS);
	localparam int CQ_W  = 32 + AW + 1;

	logic [STEP_W-1:0] unit_step_q;
	logic              cq_wr, cq_full, cq_rd, cq_empty;
	logic [31:0]       f_value;
	logic [AW-1:0]     f_addr;
	logic              f_last;
	logic [CQ_W-1:0]   cq_head;
	logic              oq_wr, oq_full;
	out_item_t         oq_data;

	// Step register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			unit_step_q <= cfg_data;
		end
	end

	ebs_front #(.CELLS(CELLS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cq_wr    (cq_wr),
		.cq_value (f_value),
		.cq_addr  (f_addr),
		.cq_last  (f_last),
		.cq_full  (cq_full)
	);

	ebs_fifo #(.WIDTH(CQ_W), .DEPTH(CELL_Q_DEPTH)) u_cell_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cq_wr),
		.wdata  ({f_value, f_addr, f_last}),
		.full   (cq_full),
		.rd     (cq_rd),
		.rdata  (cq_head),
		.empty  (cq_empty)
	);

	ebs_back #(.TILE_EDGE(TILE_EDGE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.unit_step (unit_step_q),
		.cq_empty  (cq_empty),
		.cq_value  (cq_head[CQ_W-1 -: 32]),
		.cq_addr   (cq_head[AW:1]),
		.cq_last   (cq_head[0]),
		.cq_rd     (cq_rd),
		.oq_wr     (oq_wr),
		.oq_data   (oq_data),
		.oq_full   (oq_full)
	);

	ebs_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_Q_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (oq_wr),
		.wdata  (oq_data),
		.full   (oq_full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
